>>> hw/rtl/luhn_pkg.sv
// shared types and constants for the luhn card number classifier
`timescale 1ns / 1ps
`default_nettype none
package luhn_pkg;

  localparam int CARD_W     = 63;
  localparam int NUM_DIGITS = 19;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int POS_W      = $clog2(NUM_DIGITS + 1);
  localparam int BRAND_W    = 2;

  localparam logic [POS_W-1:0] LEN_SHORT = POS_W'(13);
  localparam logic [POS_W-1:0] LEN_AMEX  = POS_W'(15);
  localparam logic [POS_W-1:0] LEN_LONG  = POS_W'(16);

  typedef logic [DIGIT_W-1:0] digit_t;

  localparam digit_t DIG_THREE = 4'd3;
  localparam digit_t DIG_FOUR  = 4'd4;
  localparam digit_t DIG_FIVE  = 4'd5;
  localparam digit_t DIG_SEVEN = 4'd7;
  localparam digit_t DIG_ONE   = 4'd1;

  typedef enum logic [BRAND_W-1:0] {
    BRAND_INVALID    = 2'd0,
    BRAND_VISA       = 2'd1,
    BRAND_MASTERCARD = 2'd2,
    BRAND_AMEX       = 2'd3
  } brand_t;

  typedef struct packed {
    logic [POS_W-1:0] count;
    digit_t           top;
    digit_t           second;
    logic             sum_ok;
  } scan_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/luhn_bcd_conv.sv
// bit-serial binary to decimal converter (shift and add three)
`timescale 1ns / 1ps
`default_nettype none
module luhn_bcd_conv
  import luhn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [CARD_W-1:0] card_number,
  output logic [BCD_W-1:0]       bcd,
  output logic                   done
);

  localparam int CNT_W = $clog2(CARD_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(CARD_W - 1);

  logic [CARD_W-1:0] bin;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [BCD_W-1:0]  adj;
  logic [BCD_W-1:0]  bcd_next;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIG_FIVE) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIG_THREE;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
    bcd_next = {adj[BCD_W-2:0], bin[CARD_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST_BIT);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_BIT) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= card_number;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[CARD_W-2:0], 1'b0};
      bcd <= bcd_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/luhn_digit_scan.sv
// digit-serial luhn sum, length and leading digit tracker
`timescale 1ns / 1ps
`default_nettype none
module luhn_digit_scan
  import luhn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [BCD_W-1:0] bcd,
  output scan_res_t             res,
  output logic                  done
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

  logic [BCD_W-1:0] sh;
  logic [POS_W-1:0] pos;
  logic             busy;
  digit_t           sum;
  digit_t           prev;
  digit_t           d;
  logic [4:0]       d2;
  logic [4:0]       dd;
  logic [4:0]       s;
  logic [POS_W-1:0] count;
  digit_t           top;
  digit_t           second;

  assign d = sh[DIGIT_W-1:0];

  always_comb begin
    d2 = {d, 1'b0};
    if (pos[0]) begin
      dd = (d2 >= 5'd10) ? d2 - 5'd9 : d2;
    end else begin
      dd = {1'b0, d};
    end
    s = {1'b0, sum} + dd;
  end

  assign res = {count, top, second, (sum == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pos  <= '0;
    end else begin
      done <= busy && (pos == LAST_POS);
      if (start) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (busy) begin
        pos <= pos + POS_W'(1);
        if (pos == LAST_POS) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh     <= bcd;
      sum    <= '0;
      prev   <= '0;
      count  <= '0;
      top    <= '0;
      second <= '0;
    end else if (busy) begin
      sh   <= {{DIGIT_W{1'b0}}, sh[BCD_W-1:DIGIT_W]};
      sum  <= (s >= 5'd10) ? DIGIT_W'(s - 5'd10) : s[DIGIT_W-1:0];
      prev <= d;
      if (d != '0) begin
        count  <= pos + POS_W'(1);
        top    <= d;
        second <= prev;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/luhn_card_number_classifier.sv
// top level: luhn check and brand classification of a binary card number
// One card number is taken at a time and gives one brand code. The number is
// converted to decimal one bit per cycle, then the digits are scanned one per
// cycle for the luhn sum, the length and the leading digits; the bit-serial
// decimal conversion is the longer of the two steps. The result sits in an
// output register, so the next number is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module luhn_card_number_classifier
  import luhn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              card_valid,
  output logic                   card_stall,
  input  wire logic [CARD_W-1:0] card_number,
  output logic                   brand_valid,
  input  wire logic              brand_stall,
  output logic [BRAND_W-1:0]     brand_code
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CONV   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic             accept;
  logic             conv_done;
  logic [BCD_W-1:0] bcd;
  logic             scan_done;
  scan_res_t        res;
  brand_t           brand;
  logic             out_free;
  logic             load;

  assign card_stall = (state != ST_IDLE);
  assign accept     = card_valid && !card_stall;
  assign out_free   = !brand_valid || !brand_stall;

  luhn_bcd_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .card_number (card_number),
    .bcd         (bcd),
    .done        (conv_done)
  );

  luhn_digit_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (conv_done),
    .bcd   (bcd),
    .res   (res),
    .done  (scan_done)
  );

  always_comb begin
    brand = BRAND_INVALID;
    if (res.sum_ok) begin
      case (res.count)
        LEN_LONG: begin
          if (res.top == DIG_FOUR) begin
            brand = BRAND_VISA;
          end else if (res.top == DIG_FIVE && res.second >= DIG_ONE
                       && res.second <= DIG_FIVE) begin
            brand = BRAND_MASTERCARD;
          end
        end
        LEN_AMEX: begin
          if (res.top == DIG_THREE
              && (res.second == DIG_FOUR || res.second == DIG_SEVEN)) begin
            brand = BRAND_AMEX;
          end
        end
        LEN_SHORT: begin
          if (res.top == DIG_FOUR) begin
            brand = BRAND_VISA;
          end
        end
        default: brand = BRAND_INVALID;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          load       = out_free;
          state_next = out_free ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        load = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      brand_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        brand_valid <= 1'b1;
      end else if (!brand_stall) begin
        brand_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      brand_code <= brand;
    end
  end

endmodule
`default_nettype wire
